// ----- hdl/srg_pkg.sv -----
// Shared constants, command and status types, and arithmetic for the subtractive generator.
package srg_pkg;

  localparam int unsigned ValueWidth = 30;
  localparam int unsigned SeedWidth  = 28;
  localparam int unsigned AddrWidth  = 6;
  localparam int unsigned TableLen   = 55;

  localparam logic [ValueWidth-1:0] Modulus   = 30'd1000000000;
  localparam logic [SeedWidth-1:0]  SeedBase  = 28'd161803398;
  localparam logic [AddrWidth-1:0]  LastIdx   = 6'd54;
  localparam logic [AddrWidth-1:0]  FillStep  = 6'd21;
  localparam logic [AddrWidth-1:0]  BackStart = 6'd31;
  localparam logic [AddrWidth-1:0]  WrapPos   = 6'd56;
  localparam logic [AddrWidth-1:0]  FillLast  = 6'd53;
  localparam logic [1:0]            LastPass  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED_LAST,
    OP_FILL,
    OP_MIX_RD,
    OP_MIX_WR,
    OP_DRAW_RD,
    OP_DRAW_WR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
    logic out_busy;
  } dp_status_t;

  // Difference of two residues, wrapped back into the range of the modulus.
  function automatic logic [ValueWidth-1:0] sub_wrap(input logic [ValueWidth-1:0] a,
                                                     input logic [ValueWidth-1:0] b);
    logic [ValueWidth-1:0] diff;
    diff = a - b;
    if (a < b) begin
      diff = diff + Modulus;
    end
    return diff;
  endfunction

endpackage

// ----- hdl/srg_ctrl.sv -----
// Sequencer that sets the seeding, mixing and draw steps of the subtractive generator.
module srg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  srg_pkg::dp_status_t status_i,
  output srg_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_LAST,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_e;

  state_e state_q;
  logic   seeded_q;
  logic   in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.op = srg_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.op = srg_pkg::OP_LOAD;
        end
      end
      ST_SEED_LAST: cmd_o.op = srg_pkg::OP_SEED_LAST;
      ST_FILL:      cmd_o.op = srg_pkg::OP_FILL;
      ST_MIX_RD:    cmd_o.op = srg_pkg::OP_MIX_RD;
      ST_MIX_WR:    cmd_o.op = srg_pkg::OP_MIX_WR;
      ST_DRAW_RD:   cmd_o.op = srg_pkg::OP_DRAW_RD;
      ST_DRAW_WR: begin
        if (!status_i.out_busy) begin
          cmd_o.op = srg_pkg::OP_DRAW_WR;
        end
      end
      default:      cmd_o.op = srg_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seeded_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (command_i || !seeded_q) begin
              state_q <= ST_SEED_LAST;
            end else begin
              state_q <= ST_DRAW_RD;
            end
          end
        end
        ST_SEED_LAST: begin
          seeded_q <= 1'b1;
          state_q  <= ST_FILL;
        end
        ST_FILL: begin
          if (status_i.fill_last) begin
            state_q <= ST_MIX_RD;
          end
        end
        ST_MIX_RD: state_q <= ST_MIX_WR;
        ST_MIX_WR: begin
          if (status_i.mix_last) begin
            state_q <= ST_DRAW_RD;
          end else begin
            state_q <= ST_MIX_RD;
          end
        end
        ST_DRAW_RD: state_q <= ST_DRAW_WR;
        ST_DRAW_WR: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/srg_datapath.sv -----
// Lag table memory, seeding and mixing counters, pointers and output register.
module srg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srg_pkg::dp_cmd_t                    cmd_i,
  output srg_pkg::dp_status_t                 status_o,
  input  logic [srg_pkg::SeedWidth-1:0]       seed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [srg_pkg::ValueWidth-1:0]      value_o
);

  logic [srg_pkg::ValueWidth-1:0] table_q [0:srg_pkg::TableLen-1];
  logic [srg_pkg::ValueWidth-1:0] rd_a_q, rd_b_q;
  logic [srg_pkg::ValueWidth-1:0] cur_q, nxt_q;
  logic [srg_pkg::AddrWidth-1:0]  fill_pos_q, fill_cnt_q;
  logic [srg_pkg::AddrWidth-1:0]  mix_a_q, mix_b_q;
  logic [1:0]                     pass_q;
  logic [srg_pkg::AddrWidth-1:0]  front_q, back_q;
  logic [srg_pkg::AddrWidth-1:0]  front_d, back_d;
  logic [srg_pkg::AddrWidth-1:0]  rd_addr_a, rd_addr_b;
  logic                           rd_en;
  logic [srg_pkg::AddrWidth-1:0]  wr_addr;
  logic [srg_pkg::ValueWidth-1:0] wr_data;
  logic                           wr_en;
  logic [srg_pkg::SeedWidth-1:0]  seed_diff;
  logic [srg_pkg::AddrWidth:0]    fill_pos_sum;
  logic [srg_pkg::ValueWidth-1:0] diff;
  logic                           out_valid_q;
  logic [srg_pkg::ValueWidth-1:0] value_q;

  assign seed_diff = (seed_i >= srg_pkg::SeedBase) ? (seed_i - srg_pkg::SeedBase)
                                                   : (srg_pkg::SeedBase - seed_i);
  assign fill_pos_sum = {1'b0, fill_pos_q} + {1'b0, srg_pkg::FillStep};
  assign diff = srg_pkg::sub_wrap(rd_a_q, rd_b_q);

  always_comb begin
    front_d = front_q + 6'd1;
    if (front_d == srg_pkg::WrapPos) begin
      front_d = 6'd1;
    end
    back_d = back_q + 6'd1;
    if (back_d == srg_pkg::WrapPos) begin
      back_d = 6'd1;
    end
  end

  always_comb begin
    rd_addr_a = mix_a_q;
    rd_addr_b = mix_b_q;
    if (cmd_i.op == srg_pkg::OP_DRAW_RD) begin
      rd_addr_a = front_d - 6'd1;
      rd_addr_b = back_d - 6'd1;
    end
  end

  // The read words are held until the following write step, however long it waits.
  assign rd_en = (cmd_i.op == srg_pkg::OP_MIX_RD) || (cmd_i.op == srg_pkg::OP_DRAW_RD);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mix_a_q;
    wr_data = diff;
    case (cmd_i.op)
      srg_pkg::OP_SEED_LAST: begin
        wr_en   = 1'b1;
        wr_addr = srg_pkg::LastIdx;
        wr_data = cur_q;
      end
      srg_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_pos_q - 6'd1;
        wr_data = nxt_q;
      end
      srg_pkg::OP_MIX_WR: begin
        wr_en = 1'b1;
      end
      srg_pkg::OP_DRAW_WR: begin
        wr_en   = 1'b1;
        wr_addr = front_q - 6'd1;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= table_q[rd_addr_a];
      rd_b_q <= table_q[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      srg_pkg::OP_LOAD: begin
        cur_q      <= {2'b00, seed_diff};
        nxt_q      <= 30'd1;
        fill_pos_q <= srg_pkg::FillStep;
        fill_cnt_q <= '0;
        mix_a_q    <= '0;
        mix_b_q    <= srg_pkg::BackStart;
        pass_q     <= '0;
      end
      srg_pkg::OP_FILL: begin
        nxt_q      <= srg_pkg::sub_wrap(cur_q, nxt_q);
        cur_q      <= nxt_q;
        fill_cnt_q <= fill_cnt_q + 6'd1;
        if (fill_pos_sum >= 7'(srg_pkg::TableLen)) begin
          fill_pos_q <= srg_pkg::AddrWidth'(fill_pos_sum - 7'(srg_pkg::TableLen));
        end else begin
          fill_pos_q <= fill_pos_sum[srg_pkg::AddrWidth-1:0];
        end
      end
      srg_pkg::OP_MIX_WR: begin
        if (mix_a_q == srg_pkg::LastIdx) begin
          mix_a_q <= '0;
          pass_q  <= pass_q + 2'd1;
        end else begin
          mix_a_q <= mix_a_q + 6'd1;
        end
        if (mix_b_q == srg_pkg::LastIdx) begin
          mix_b_q <= '0;
        end else begin
          mix_b_q <= mix_b_q + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= srg_pkg::BackStart;
    end else if (cmd_i.op == srg_pkg::OP_SEED_LAST) begin
      front_q <= '0;
      back_q  <= srg_pkg::BackStart;
    end else if (cmd_i.op == srg_pkg::OP_DRAW_RD) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == srg_pkg::OP_DRAW_WR) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == srg_pkg::OP_DRAW_WR) begin
      value_q <= diff;
    end
  end

  assign status_o.fill_last = (fill_cnt_q == srg_pkg::FillLast);
  assign status_o.mix_last  = (mix_a_q == srg_pkg::LastIdx) && (pass_q == srg_pkg::LastPass);
  assign status_o.out_busy  = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;

endmodule

// ----- hdl/subtractive_random_generator.sv -----
// Subtractive lagged random generator over a 55-word table, one value per request.
// A draw accepts the request, reads both lagged words from the table memory, and then
// writes their wrapped difference back and loads it into the output register. A reseed,
// and the first request after reset, first writes all 55 table words and then runs four
// mixing passes of 55 read-then-write steps each, all through the single write port of
// the table memory. A new request is taken once the previous value is in the output
// register, even while that value still waits to be taken.
module subtractive_random_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [srg_pkg::SeedWidth-1:0]  seed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [srg_pkg::ValueWidth-1:0] value_o
);

  srg_pkg::dp_cmd_t    dp_cmd;
  srg_pkg::dp_status_t dp_status;

  srg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  srg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule

// ----- hdl/srg_checker.sv -----
// Port checker for the subtractive generator and its bind to the top level.
module srg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           command_i,
  input logic [srg_pkg::SeedWidth-1:0]  seed_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [srg_pkg::ValueWidth-1:0] value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("Stalled output transfer changed.");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> value_o < srg_pkg::Modulus)
    else $error("Output value is not below the modulus.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input was not stalled after a transfer.");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("A result appeared with no request in progress.");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (.*);
